// ===== rtl/core/iedd_pkg.sv =====
// Shared constants, types and command/status structs of the insert/delete edit distance block.
package iedd_pkg;

  localparam int MAX_LEN = 64;
  localparam int SYM_W   = 8;
  localparam int DIST_W  = 8;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int COST_W  = $clog2(2 * MAX_LEN + 1);

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_FIRST   = 2'd0;
  localparam kind_t KIND_SECOND  = 2'd1;
  localparam kind_t KIND_COMPUTE = 2'd2;
  localparam kind_t KIND_NONE    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_ROW,
    S_CELL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;       // input transfer of an append item
    logic start;      // input transfer of a compute item
    logic init_step;  // write one entry of the starting cost row
    logic row_start;  // begin a row: fetch first-string symbol, prime reads
    logic cell_step;  // evaluate one cell and write it back
    logic finish;     // move the result into the output register, clear strings
  } dp_cmd_t;

  typedef struct packed {
    logic any_empty;  // one of the strings is empty
    logic j_at_n;     // column counter on the last column
    logic i_at_m;     // row counter on the last row
    logic out_free;   // output register can take a result this cycle
  } dp_status_t;

  // Clamp a cost to the width of the distance field.
  function automatic logic [DIST_W-1:0] sat_dist(input logic [COST_W-1:0] c);
    logic [31:0] wide;
    wide = 32'(c);
    if (wide > 32'(2 ** DIST_W - 1)) begin
      return {DIST_W{1'b1}};
    end
    return wide[DIST_W-1:0];
  endfunction

endpackage

// ===== rtl/core/iedd_ctrl.sv =====
// Sequencer for loading, row initialisation, the cell sweep and result hand-off.
module iedd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  iedd_pkg::kind_t      in_kind,
  output logic                 in_tready,
  input  iedd_pkg::dp_status_t status,
  output iedd_pkg::dp_cmd_t    cmd
);
  import iedd_pkg::*;

  state_t state_r, state_nxt;
  logic   xfer;

  assign in_tready = (state_r == S_IDLE);
  assign xfer      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (xfer && in_kind == KIND_COMPUTE) begin
          state_nxt = status.any_empty ? S_DONE : S_INIT;
        end
      end
      S_INIT: begin
        if (status.j_at_n) begin
          state_nxt = S_ROW;
        end
      end
      S_ROW:  state_nxt = S_CELL;
      S_CELL: begin
        if (status.j_at_n) begin
          state_nxt = status.i_at_m ? S_DONE : S_ROW;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load  = xfer && (in_kind == KIND_FIRST || in_kind == KIND_SECOND);
        cmd.start = xfer && (in_kind == KIND_COMPUTE);
      end
      S_INIT:  cmd.init_step = 1'b1;
      S_ROW:   cmd.row_start = 1'b1;
      S_CELL:  cmd.cell_step = 1'b1;
      S_DONE:  cmd.finish    = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/core/iedd_datapath.sv =====
// String stores, cost-row memory, cell arithmetic and the output register.
module iedd_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  iedd_pkg::kind_t               in_kind,
  input  logic [iedd_pkg::SYM_W-1:0]    in_symbol,
  input  iedd_pkg::dp_cmd_t             cmd,
  output iedd_pkg::dp_status_t          status,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [iedd_pkg::DIST_W-1:0]   out_distance,
  output logic                          out_overflow
);
  import iedd_pkg::*;

  logic [SYM_W-1:0]  s1_mem [MAX_LEN];
  logic [SYM_W-1:0]  s2_mem [MAX_LEN];
  logic [COST_W-1:0] cost_mem [MAX_LEN];

  logic [LEN_W-1:0]  m_r, n_r, i_r, j_r;
  logic              ovf_r;
  logic [SYM_W-1:0]  a_r, s2_rd_r;
  logic [COST_W-1:0] up_rd_r, left_r, diag_r;
  logic              out_valid_r, out_ovf_r;
  logic [DIST_W-1:0] out_dist_r;

  logic              m_full, n_full;
  logic [IDX_W-1:0]  rd_idx, wr_idx;
  logic [COST_W-1:0] best, min_ul, wr_cost, result;

  assign m_full = (m_r == LEN_W'(MAX_LEN));
  assign n_full = (n_r == LEN_W'(MAX_LEN));

  assign status.any_empty = (m_r == '0) || (n_r == '0);
  assign status.j_at_n    = (j_r == n_r);
  assign status.i_at_m    = (i_r == m_r);
  assign status.out_free  = !out_valid_r || out_tready;

  // Row start primes column 1; each cell step prefetches the next column.
  assign rd_idx = cmd.row_start ? '0 : j_r[IDX_W-1:0];
  assign wr_idx = IDX_W'(j_r - LEN_W'(1));

  always_comb begin
    min_ul = (up_rd_r < left_r) ? up_rd_r : left_r;
    best   = min_ul + COST_W'(1);
    if (a_r == s2_rd_r && diag_r < best) begin
      best = diag_r;
    end
  end

  assign wr_cost = cmd.cell_step ? best : COST_W'(j_r);

  always_comb begin
    if (m_r == '0) begin
      result = COST_W'(n_r);
    end else if (n_r == '0) begin
      result = COST_W'(m_r);
    end else begin
      result = left_r;
    end
  end

  // Memories
  always_ff @(posedge clk) begin
    if (cmd.load && in_kind == KIND_FIRST && !m_full) begin
      s1_mem[m_r[IDX_W-1:0]] <= in_symbol;
    end
    if (cmd.load && in_kind == KIND_SECOND && !n_full) begin
      s2_mem[n_r[IDX_W-1:0]] <= in_symbol;
    end
    if (cmd.init_step || cmd.cell_step) begin
      cost_mem[wr_idx] <= wr_cost;
    end
    up_rd_r <= cost_mem[rd_idx];
    s2_rd_r <= s2_mem[rd_idx];
    if (cmd.row_start) begin
      a_r <= s1_mem[IDX_W'(i_r - LEN_W'(1))];
    end
  end

  // Cell registers
  always_ff @(posedge clk) begin
    if (cmd.row_start) begin
      diag_r <= COST_W'(i_r - LEN_W'(1));
      left_r <= COST_W'(i_r);
    end else if (cmd.cell_step) begin
      diag_r <= up_rd_r;
      left_r <= best;
    end
  end

  // Lengths, counters and sticky overflow
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r   <= '0;
      n_r   <= '0;
      ovf_r <= 1'b0;
      i_r   <= '0;
      j_r   <= '0;
    end else begin
      if (cmd.load) begin
        if (in_kind == KIND_FIRST) begin
          if (m_full) ovf_r <= 1'b1;
          else        m_r   <= m_r + LEN_W'(1);
        end else begin
          if (n_full) ovf_r <= 1'b1;
          else        n_r   <= n_r + LEN_W'(1);
        end
      end
      if (cmd.start) begin
        i_r <= LEN_W'(1);
        j_r <= LEN_W'(1);
      end else if (cmd.init_step) begin
        j_r <= status.j_at_n ? LEN_W'(1) : j_r + LEN_W'(1);
      end else if (cmd.row_start) begin
        j_r <= LEN_W'(1);
      end else if (cmd.cell_step) begin
        j_r <= j_r + LEN_W'(1);
        if (status.j_at_n && !status.i_at_m) begin
          i_r <= i_r + LEN_W'(1);
        end
      end
      if (cmd.finish) begin
        m_r   <= '0;
        n_r   <= '0;
        ovf_r <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_dist_r <= sat_dist(result);
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_distance = out_dist_r;
  assign out_overflow = out_ovf_r;

endmodule

// ===== rtl/core/indel_edit_distance.sv =====
// Top level of the insert/delete edit distance engine.
//
// Append items (tuser 0 or 1) store one byte into the first or second string; up to
// 64 symbols per string are kept, further ones are dropped and flagged.
// A compute item (tuser 2) runs a cost-row sweep over one memory with a read and a
// write port: the cost row is seeded entry by entry for the n symbols of the second
// string, then each of the m rows takes a row fetch plus one cell per cycle, and then
// the result is loaded into the output register once it is free; an empty string
// skips the sweep. Throughput is set by the one cost-row memory port pair, which
// evaluates one cell per cycle. Input is taken only between computations; a finished
// result sits in the output register until taken, while loading of the next strings
// goes ahead. tuser 3 is ignored.
module indel_edit_distance (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] symbol
  input  logic [1:0]                   in_tuser,   // [1:0] kind
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [7:0]                   out_tdata,  // [7:0] distance
  output logic                         out_tuser   // [0] overflow
);
  import iedd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  iedd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (kind_t'(in_tuser)),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  iedd_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_kind      (kind_t'(in_tuser)),
    .in_symbol    (in_tdata),
    .cmd          (cmd),
    .status       (status),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_distance (out_tdata),
    .out_overflow (out_tuser)
  );

endmodule

// ===== tb/indel_edit_distance_checker.sv =====
// Checker for the insert/delete edit distance block: predicts each result and compares.
module indel_edit_distance_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] symbol
  input  logic [1:0] in_tuser,   // [1:0] kind
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [7:0] distance
  input  logic       out_tuser,  // [0] overflow
  output int         mismatches,
  output int         outstanding,
  output int         results_checked,
  output int         overflow_results
);
  timeunit 1ns;
  timeprecision 1ps;
  import iedd_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } indel_result_t;

  logic [SYM_W-1:0] first_syms [$];
  logic [SYM_W-1:0] second_syms [$];
  logic             symbols_dropped = 1'b0;
  indel_result_t    expected_distances [$];
  int               err_count = 0;
  int               seen_count = 0;
  int               ovf_count = 0;
  int               pending_count = 0;

  assign mismatches       = err_count;
  assign outstanding      = pending_count;
  assign results_checked  = seen_count;
  assign overflow_results = ovf_count;

  // Distance from the longest common subsequence: every unmatched symbol costs one.
  function automatic logic [DIST_W-1:0] lcs_indel_distance();
    int prev_row [$];
    int cur_row [$];
    int best;
    int d;
    for (int j = 0; j <= second_syms.size(); j++) begin
      prev_row.push_back(0);
    end
    for (int i = 1; i <= first_syms.size(); i++) begin
      cur_row.delete();
      cur_row.push_back(0);
      for (int j = 1; j <= second_syms.size(); j++) begin
        if (first_syms[i-1] == second_syms[j-1]) begin
          best = prev_row[j-1] + 1;
        end else begin
          best = (prev_row[j] > cur_row[j-1]) ? prev_row[j] : cur_row[j-1];
        end
        cur_row.push_back(best);
      end
      prev_row = cur_row;
    end
    d = first_syms.size() + second_syms.size() - 2 * prev_row[second_syms.size()];
    if (d > 2 ** DIST_W - 1) begin
      d = 2 ** DIST_W - 1;
    end
    return d[DIST_W-1:0];
  endfunction

  always @(posedge clk) begin
    indel_result_t got;
    indel_result_t want;
    if (!rst_n) begin
      first_syms.delete();
      second_syms.delete();
      symbols_dropped = 1'b0;
      expected_distances.delete();
    end else begin
      // result side first: a result can never belong to a compute accepted on the same edge
      if (out_tvalid && out_tready) begin
        got.distance = out_tdata;
        got.overflow = out_tuser;
        seen_count++;
        if (expected_distances.size() == 0) begin
          err_count++;
          if (err_count <= 10) begin
            $display("%0t: unexpected result, distance %0d overflow %0b",
                     $realtime, got.distance, got.overflow);
          end
        end else begin
          want = expected_distances.pop_front();
          if (got.distance !== want.distance || got.overflow !== want.overflow) begin
            err_count++;
            if (err_count <= 10) begin
              $display("%0t: mismatch, expected distance %0d overflow %0b,",
                       $realtime, want.distance, want.overflow,
                       " got distance %0d overflow %0b", got.distance, got.overflow);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        case (kind_t'(in_tuser))
          KIND_FIRST: begin
            if (first_syms.size() < MAX_LEN) begin
              first_syms.push_back(in_tdata);
            end else begin
              symbols_dropped = 1'b1;
            end
          end
          KIND_SECOND: begin
            if (second_syms.size() < MAX_LEN) begin
              second_syms.push_back(in_tdata);
            end else begin
              symbols_dropped = 1'b1;
            end
          end
          KIND_COMPUTE: begin
            want.distance = lcs_indel_distance();
            want.overflow = symbols_dropped;
            expected_distances.push_back(want);
            if (symbols_dropped) begin
              ovf_count++;
            end
            first_syms.delete();
            second_syms.delete();
            symbols_dropped = 1'b0;
          end
          default: ;
        endcase
      end
    end
    pending_count = expected_distances.size();
  end

endmodule

// ===== tb/tb_indel_edit_distance.sv =====
// Testbench top for the insert/delete edit distance block: clock, reset, stimulus, verdict.
module tb_indel_edit_distance;
  timeunit 1ns;
  timeprecision 1ps;
  import iedd_pkg::*;

  localparam int TARGET_ITEMS = 1650;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 200;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic [1:0] in_tuser;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tuser;

  int mismatches;
  int outstanding;
  int results_checked;
  int overflow_results;
  int items_sent;
  int pairs_sent;
  int longest_load;
  bit sender_burst;

  indel_edit_distance uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  indel_edit_distance_checker result_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .results_checked  (results_checked),
    .overflow_results (overflow_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(16, 80);
  endfunction

  function automatic int sender_gap();
    if (sender_burst) return 0;
    if ($urandom_range(0, 99) < 55) return 0;
    return idle_length();
  endfunction

  function automatic logic [7:0] pick_symbol(input bit narrow, input logic [7:0] base);
    if (narrow) return base + 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_item(input kind_t kind, input logic [7:0] sym);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= sym;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind != KIND_NONE) begin
      items_sent++;
    end
  endtask

  // loads both strings in a random interleaving, with some ignored items mixed in, then computes
  task automatic load_and_compute(input logic [7:0] first_q[$], input logic [7:0] second_q[$]);
    int ia;
    int ib;
    ia = 0;
    ib = 0;
    if (first_q.size() > longest_load) longest_load = first_q.size();
    if (second_q.size() > longest_load) longest_load = second_q.size();
    while (ia < first_q.size() || ib < second_q.size()) begin
      if ($urandom_range(0, 99) < 3) begin
        send_item(KIND_NONE, 8'($urandom_range(0, 255)));
      end
      if (ia < first_q.size() && (ib >= second_q.size() || $urandom_range(0, 1) == 1)) begin
        send_item(KIND_FIRST, first_q[ia]);
        ia++;
      end else begin
        send_item(KIND_SECOND, second_q[ib]);
        ib++;
      end
    end
    send_item(KIND_COMPUTE, 8'($urandom_range(0, 255)));
    pairs_sent++;
  endtask

  // receiver: random stalls, steady stretches, and two long hold-offs to back up the input
  initial begin
    int stall_left;
    int mode_left;
    bit steady;
    bit first_hold_done;
    bit second_hold_done;
    stall_left = 0;
    mode_left = 0;
    steady = 1'b0;
    first_hold_done = 1'b0;
    second_hold_done = 1'b0;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        steady = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      if (!first_hold_done && results_checked >= 25) begin
        first_hold_done = 1'b1;
        stall_left = 500;
      end else if (!second_hold_done && results_checked >= 60) begin
        second_hold_done = 1'b1;
        stall_left = 500;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (steady || $urandom_range(0, 99) < 65) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        stall_left = idle_length() - 1;
      end
    end
  end

  initial begin
    logic [7:0] first_q[$];
    logic [7:0] second_q[$];
    logic [7:0] base;
    int         seq;
    int         first_len;
    int         second_len;
    int         r;
    bit         narrow;
    bit         related;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_NONE;
    items_sent = 0;
    pairs_sent = 0;
    longest_load = 0;
    sender_burst = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed: both empty, one side empty, extreme symbols, ignored kind, reordered pair
    send_item(KIND_COMPUTE, 8'hFF);
    send_item(KIND_FIRST, 8'h00);
    send_item(KIND_FIRST, 8'hFF);
    send_item(KIND_COMPUTE, 8'h00);
    send_item(KIND_SECOND, 8'hFF);
    send_item(KIND_SECOND, 8'h00);
    send_item(KIND_NONE, 8'h5A);
    send_item(KIND_COMPUTE, 8'hA5);
    send_item(KIND_FIRST, 8'hAA);
    send_item(KIND_SECOND, 8'h55);
    send_item(KIND_FIRST, 8'h55);
    send_item(KIND_SECOND, 8'hAA);
    send_item(KIND_COMPUTE, 8'h00);
    send_item(KIND_FIRST, 8'h81);
    send_item(KIND_FIRST, 8'h7E);
    send_item(KIND_SECOND, 8'h81);
    send_item(KIND_SECOND, 8'h7E);
    send_item(KIND_COMPUTE, 8'h3C);
    send_item(KIND_FIRST, 8'h01);
    send_item(KIND_FIRST, 8'h02);
    send_item(KIND_FIRST, 8'h03);
    send_item(KIND_SECOND, 8'h04);
    send_item(KIND_COMPUTE, 8'hC3);
    send_item(KIND_NONE, 8'hFF);
    send_item(KIND_COMPUTE, 8'h00);

    seq = 0;
    while (items_sent < TARGET_ITEMS) begin
      first_q.delete();
      second_q.delete();
      sender_burst = ($urandom_range(0, 3) == 0);
      narrow = ($urandom_range(0, 1) == 1);
      base = 8'($urandom_range(0, 252));
      related = ($urandom_range(0, 99) < 40);
      r = $urandom_range(0, 99);
      if (seq == 0) begin
        // both strings exactly full and equal
        first_len = MAX_LEN;
        second_len = MAX_LEN;
        narrow = 1'b0;
        related = 1'b1;
      end else if (seq == 1) begin
        // both strings past capacity
        first_len = MAX_LEN + 6;
        second_len = MAX_LEN + 2;
        narrow = 1'b1;
        related = 1'b0;
      end else if (r < 5) begin
        // noise only, then a compute on empty strings
        first_len = 0;
        second_len = 0;
        repeat ($urandom_range(1, 3)) send_item(KIND_NONE, 8'($urandom_range(0, 255)));
      end else if (r < 72) begin
        first_len = $urandom_range(0, 8);
        second_len = $urandom_range(0, 8);
      end else if (r < 91) begin
        first_len = $urandom_range(0, 20);
        second_len = $urandom_range(0, 20);
      end else if (r < 97) begin
        first_len = $urandom_range(0, 40);
        second_len = $urandom_range(0, 40);
      end else begin
        first_len = $urandom_range(MAX_LEN - 9, MAX_LEN + 8);
        second_len = $urandom_range(MAX_LEN - 9, MAX_LEN + 8);
      end
      for (int k = 0; k < first_len; k++) begin
        first_q.push_back(pick_symbol(narrow, base));
      end
      if (related) begin
        second_q = first_q;
        if (seq != 0) begin
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1) == 0 && second_q.size() > 0) begin
              second_q.delete($urandom_range(0, second_q.size() - 1));
            end else begin
              second_q.insert($urandom_range(0, second_q.size()), pick_symbol(narrow, base));
            end
          end
        end
      end else begin
        for (int k = 0; k < second_len; k++) begin
          second_q.push_back(pick_symbol(narrow, base));
        end
      end
      load_and_compute(first_q, second_q);
      seq++;
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Loaded and computed %0d string pairs (%0d transfers, strings up to %0d symbols).",
             pairs_sent, items_sent, longest_load);
    $display("Checked %0d distances, %0d with dropped symbols; %0d mismatches.",
             results_checked, overflow_results, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
